>>> rtl/pic_pkg.sv
// shared types and constants of the interrupt controller
package pic_pkg;

  localparam int NUM_LINES = 8;
  localparam int LINE_W    = $clog2(NUM_LINES);
  localparam int BYTE_W    = 8;

  // operation kinds carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_RAISE = 2'd2,
    FUNC_ACK   = 2'd3
  } func_t;

  // shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // initialization phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ICW2 = 3'd2;
  localparam logic [2:0] PH_ICW3 = 3'd3;
  localparam logic [2:0] PH_ICW4 = 3'd4;

  // command byte decode
  localparam logic [7:0] ICW1_FLAG    = 8'h10;
  localparam logic [7:0] OCW_KIND_MSK = 8'h18;
  localparam logic [7:0] OCW2_KIND    = 8'h00;
  localparam logic [7:0] OCW3_KIND    = 8'h08;
  localparam logic [2:0] OCW2_NS_EOI  = 3'd1;
  localparam logic [1:0] SEL_IRR      = 2'd2;
  localparam logic [1:0] SEL_ISR      = 2'd3;
  localparam logic [7:0] MASK_RESET   = 8'hFF;

  // icw1 bits
  localparam int ICW1_IC4_BIT    = 0;
  localparam int ICW1_SINGLE_BIT = 1;

endpackage

>>> rtl/pic_alu.sv
// shared 8-bit add/subtract unit with a line-range flag
module pic_alu (
  input  pic_pkg::alu_op_t           op,
  input  logic [pic_pkg::BYTE_W-1:0] a,
  input  logic [pic_pkg::BYTE_W-1:0] b,
  output logic [pic_pkg::BYTE_W-1:0] res,
  output logic                       in_range
);

  always_comb begin
    case (op)
      pic_pkg::ALU_SUB: res = a - b;
      default:          res = a + b;
    endcase
  end

  // result names one of the interrupt lines
  assign in_range = (res[pic_pkg::BYTE_W-1:pic_pkg::LINE_W] == '0);

endmodule

>>> rtl/programmable_interrupt_controller.sv
// top level of the simplified eight-line interrupt controller
//
// usage:
//   input channel s_axis: one transfer per operation; tuser gives the kind
//   (read, write, raise, acknowledge) and the port address bit, tdata the
//   write byte and the raised vector
//   output channel m_axis: exactly one transfer per operation; tdata holds
//   the read byte and the granted vector, tuser flags a granted interrupt
// timing:
//   read, write and raise latch the operation, then form the result in exec
//   acknowledge scans the lines one per cycle through the shared adder,
//   from line 0 up to the lowest pending unmasked line or the last line
//   one operation is in flight at a time; s_axis_tready is high only when
//   the sequencer is idle and the result register is empty or draining
// reset (rst, synchronous): all lines masked, no requests or in-service
//   bits, initialization idle, vector base and read select zero
// stall: a result waits in the output register until m_axis_tready; the
//   next operation is then taken in the same cycle the result leaves
module programmable_interrupt_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] wdata, [15:8] vector
  input  logic [2:0]  s_axis_tuser,   // [1:0] func, [2] a0
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] rdata, [15:8] int_vector
  output logic        m_axis_tuser    // [0] int_valid
);

  localparam logic [pic_pkg::LINE_W-1:0] LAST_LINE = pic_pkg::LINE_W'(pic_pkg::NUM_LINES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  state_t state;

  // architectural registers
  logic [7:0] mask_reg;
  logic [7:0] request_reg;
  logic [7:0] in_service_reg;
  logic [2:0] init_phase;
  logic [7:0] init_word_one;
  logic [7:0] vector_base;
  logic [7:0] read_select;

  // latched operation
  pic_pkg::func_t item_func;
  logic           item_a0;
  logic [7:0]     item_wdata;
  logic [7:0]     item_vector;

  // scan index over the lines
  logic [pic_pkg::LINE_W-1:0] line_idx;

  // result register
  logic       out_valid;
  logic [7:0] out_rdata;
  logic       out_int_valid;
  logic [7:0] out_int_vector;

  // shared adder hookup
  pic_pkg::alu_op_t alu_op;
  logic [7:0]       alu_a;
  logic [7:0]       alu_b;
  logic [7:0]       alu_res;
  logic             alu_in_range;

  logic       s_xfer;
  logic [7:0] pending;
  logic [7:0] read_value;

  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign pending       = request_reg & ~mask_reg;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_int_vector, out_rdata};
  assign m_axis_tuser  = out_int_valid;

  // raise computes vector - base, the scan computes base + line
  always_comb begin
    if (state == ST_SCAN) begin
      alu_op = pic_pkg::ALU_ADD;
      alu_a  = vector_base;
      alu_b  = {{(8 - pic_pkg::LINE_W){1'b0}}, line_idx};
    end else begin
      alu_op = pic_pkg::ALU_SUB;
      alu_a  = item_vector;
      alu_b  = vector_base;
    end
  end

  pic_alu u_alu (
    .op       (alu_op),
    .a        (alu_a),
    .b        (alu_b),
    .res      (alu_res),
    .in_range (alu_in_range)
  );

  // command port reads irr or isr per ocw3, otherwise the mask
  always_comb begin
    read_value = mask_reg;
    if (!item_a0) begin
      if (read_select[1:0] == pic_pkg::SEL_IRR) begin
        read_value = request_reg;
      end else if (read_select[1:0] == pic_pkg::SEL_ISR) begin
        read_value = in_service_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      mask_reg       <= pic_pkg::MASK_RESET;
      request_reg    <= '0;
      in_service_reg <= '0;
      init_phase     <= pic_pkg::PH_IDLE;
      init_word_one  <= '0;
      vector_base    <= '0;
      read_select    <= '0;
      line_idx       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          // a result is only ever held while idle
          if (m_axis_tready) begin
            out_valid <= 1'b0;
          end
          if (s_xfer) begin
            item_func   <= pic_pkg::func_t'(s_axis_tuser[1:0]);
            item_a0     <= s_axis_tuser[2];
            item_wdata  <= s_axis_tdata[7:0];
            item_vector <= s_axis_tdata[15:8];
            state       <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_rdata      <= (item_func == pic_pkg::FUNC_READ) ? read_value : '0;
          out_int_valid  <= 1'b0;
          out_int_vector <= '0;
          // acknowledge hands over to the line scan, the rest finish here
          out_valid      <= (item_func != pic_pkg::FUNC_ACK);
          state          <= (item_func == pic_pkg::FUNC_ACK) ? ST_SCAN : ST_IDLE;
          case (item_func)
            pic_pkg::FUNC_READ: begin
              // read byte already formed above
            end
            pic_pkg::FUNC_WRITE: begin
              if (!item_a0) begin
                if ((item_wdata & pic_pkg::ICW1_FLAG) != '0) begin
                  init_word_one <= item_wdata;
                  init_phase    <= pic_pkg::PH_ICW2;
                  mask_reg      <= '0;
                end else if ((item_wdata & pic_pkg::OCW_KIND_MSK) == pic_pkg::OCW2_KIND) begin
                  if (item_wdata[7:5] == pic_pkg::OCW2_NS_EOI) begin
                    in_service_reg <= '0;
                  end
                end else if ((item_wdata & pic_pkg::OCW_KIND_MSK) == pic_pkg::OCW3_KIND) begin
                  read_select <= item_wdata;
                end
              end else begin
                case (init_phase)
                  pic_pkg::PH_ICW2: begin
                    // base must be aligned to eight vectors
                    if (item_wdata[2:0] == 3'd0) begin
                      vector_base <= item_wdata;
                      if (init_word_one[pic_pkg::ICW1_SINGLE_BIT]) begin
                        init_phase <= init_word_one[pic_pkg::ICW1_IC4_BIT] ?
                                      pic_pkg::PH_ICW4 : pic_pkg::PH_IDLE;
                      end else begin
                        init_phase <= pic_pkg::PH_ICW3;
                      end
                    end
                  end
                  pic_pkg::PH_ICW3: begin
                    init_phase <= init_word_one[pic_pkg::ICW1_IC4_BIT] ?
                                  pic_pkg::PH_ICW4 : pic_pkg::PH_IDLE;
                  end
                  pic_pkg::PH_ICW4: begin
                    init_phase <= pic_pkg::PH_IDLE;
                  end
                  default: begin
                    mask_reg <= item_wdata;
                  end
                endcase
              end
            end
            pic_pkg::FUNC_RAISE: begin
              if (alu_in_range) begin
                request_reg[alu_res[pic_pkg::LINE_W-1:0]] <= 1'b1;
              end
            end
            default: begin
              // acknowledge: scan starts at line 0
              line_idx <= '0;
            end
          endcase
        end
        ST_SCAN: begin
          if (pending[line_idx]) begin
            in_service_reg          <= 8'(1) << line_idx;
            request_reg[line_idx]   <= 1'b0;
            out_rdata               <= '0;
            out_int_valid           <= 1'b1;
            out_int_vector          <= alu_res;
            out_valid               <= 1'b1;
            state                   <= ST_IDLE;
          end else if (line_idx == LAST_LINE) begin
            out_rdata      <= '0;
            out_int_valid  <= 1'b0;
            out_int_vector <= '0;
            out_valid      <= 1'b1;
            state          <= ST_IDLE;
          end else begin
            line_idx <= line_idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == ST_IDLE))
    else $error("input ready outside idle");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_xfer |=> !s_axis_tready)
    else $error("second operation taken while one is in flight");

  a_isr_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0(in_service_reg))
    else $error("more than one in-service bit");

  a_no_grant_zero_vec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_int_valid) |-> (out_int_vector == '0))
    else $error("vector reported without a grant");

  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    (init_phase == pic_pkg::PH_IDLE) || (init_phase == pic_pkg::PH_ICW2) ||
    (init_phase == pic_pkg::PH_ICW3) || (init_phase == pic_pkg::PH_ICW4))
    else $error("initialization phase out of sequence");
`endif

endmodule
